[sv/lobm_pkg.sv]
package lobm_pkg;

  localparam int ORDER_SLOTS_DEF = 32;
  localparam int PRICE_BITS_DEF  = 16;
  localparam int SHARE_BITS_DEF  = 24;
  localparam int ID_BITS_DEF     = 24;
  localparam int AGE_BITS        = 32;

  typedef enum logic [2:0] {
    KIND_FILL      = 3'd0,
    KIND_RESTED    = 3'd1,
    KIND_FILLED    = 3'd2,
    KIND_CANCELLED = 3'd3,
    KIND_NOT_FOUND = 3'd4,
    KIND_BOOK_FULL = 3'd5
  } kind_t;

  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_CANCEL = 1'b1;

endpackage

[sv/limit_order_book_matcher.sv]
// Limit order book, price-time priority, held in ORDER_SLOTS order slots.
// Input channel in_*: one transaction per add or cancel order.
//   in_tdata  = order_id, side, shares, limit_price from the low bit up,
//   in_tuser  = mode (0 add, 1 cancel).
// Output channel out_*: one transaction per result.
//   out_tdata = incoming_id, resting_id, traded_shares, trade_price,
//   remaining_shares from the low bit up, out_tuser = kind, out_tlast marks the
//   final result of an input.
// An add item matches first: each fill needs one scan of all slots, one slot
// per cycle through a shared compare unit, followed by a fill step that
// waits for the output register to be free. A rest needs one more scan for a
// free slot. A cancel is one scan.
// in_tready is high only while the block is idle.
// Each result waits in the output register until taken; a stalled receiver
// halts the sequencer without loss.
// Reset (rst_n low, synchronous) empties the book and clears the arrival
// counter; no clearing pass is needed.
module limit_order_book_matcher
  import lobm_pkg::*;
#(
  parameter int ORDER_SLOTS = ORDER_SLOTS_DEF,
  parameter int PRICE_BITS  = PRICE_BITS_DEF,
  parameter int SHARE_BITS  = SHARE_BITS_DEF,
  parameter int ID_BITS     = ID_BITS_DEF,
  localparam int IN_W  = ID_BITS + 1 + SHARE_BITS + PRICE_BITS,
  localparam int IN_TW = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W = 2 * ID_BITS + 2 * SHARE_BITS + PRICE_BITS,
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_TW-1:0]  in_tdata,   // order_id, side, shares, limit_price
  input  logic              in_tuser,   // mode
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_TW-1:0] out_tdata,  // incoming_id, resting_id, traded_shares,
                                        // trade_price, remaining_shares
  output logic [2:0]        out_tuser,  // kind
  output logic              out_tlast
);

  localparam int SW = $clog2(ORDER_SLOTS);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_FILL  = 6'b000100,
    S_FREE  = 6'b001000,
    S_FINAL = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [ORDER_SLOTS-1:0] valid_r, valid_nxt;
  logic [ID_BITS-1:0]     mem_id    [ORDER_SLOTS];
  logic                   mem_side  [ORDER_SLOTS];
  logic [SHARE_BITS-1:0]  mem_sh    [ORDER_SLOTS];
  logic [PRICE_BITS-1:0]  mem_pr    [ORDER_SLOTS];
  logic [AGE_BITS-1:0]    mem_arr   [ORDER_SLOTS];
  logic [AGE_BITS-1:0]    arr_cnt_r, arr_cnt_nxt;

  logic                   mode_r, mode_nxt, side_r, side_nxt;
  logic [ID_BITS-1:0]     id_r, id_nxt;
  logic [SHARE_BITS-1:0]  rem_r, rem_nxt;
  logic [PRICE_BITS-1:0]  lim_r, lim_nxt;

  logic [SW-1:0]          idx_r, idx_nxt;
  logic                   found_r, found_nxt;
  logic [SW-1:0]          best_r, best_nxt;
  logic [PRICE_BITS-1:0]  bpr_r, bpr_nxt;
  logic [AGE_BITS-1:0]    bage_r, bage_nxt;
  logic [SHARE_BITS-1:0]  bsh_r, bsh_nxt;
  logic [ID_BITS-1:0]     bid_r, bid_nxt;

  logic                   ov_r, ov_nxt, olast_r, olast_nxt;
  logic [2:0]             okind_r, okind_nxt;
  logic [ID_BITS-1:0]     orest_r, orest_nxt;
  logic [SHARE_BITS-1:0]  otr_r, otr_nxt, orem_r, orem_nxt;
  logic [PRICE_BITS-1:0]  opr_r, opr_nxt;

  logic                   wr_en;
  logic [SW-1:0]          wr_sel;
  logic [SHARE_BITS-1:0]  wr_sh;
  logic                   wr_full;

  logic [SW-1:0]          cur;
  logic [AGE_BITS-1:0]    age;
  logic                   cand, better;
  logic [SHARE_BITS-1:0]  traded;

  assign cur = idx_r;
  assign age = arr_cnt_r - mem_arr[cur];

  // shared compare unit: one slot per cycle
  always_comb begin
    cand   = 1'b0;
    better = 1'b0;
    if (mode_r == MODE_CANCEL) begin
      cand   = valid_r[cur] && (mem_id[cur] == id_r);
      better = cand && !found_r;
    end else begin
      cand = valid_r[cur] && (mem_side[cur] != side_r) &&
             (side_r ? (mem_pr[cur] <= lim_r) : (mem_pr[cur] >= lim_r));
      if (cand) begin
        if (!found_r) begin
          better = 1'b1;
        end else if (mem_pr[cur] != bpr_r) begin
          better = side_r ? (mem_pr[cur] < bpr_r) : (mem_pr[cur] > bpr_r);
        end else begin
          better = age > bage_r;
        end
      end
    end
  end

  assign traded = (rem_r < bsh_r) ? rem_r : bsh_r;

  always_comb begin
    state_nxt   = state_r;
    valid_nxt   = valid_r;
    arr_cnt_nxt = arr_cnt_r;
    mode_nxt = mode_r; side_nxt = side_r; id_nxt = id_r;
    rem_nxt  = rem_r;  lim_nxt  = lim_r;
    idx_nxt = idx_r; found_nxt = found_r; best_nxt = best_r;
    bpr_nxt = bpr_r; bage_nxt = bage_r; bsh_nxt = bsh_r; bid_nxt = bid_r;
    ov_nxt = ov_r; olast_nxt = olast_r; okind_nxt = okind_r;
    orest_nxt = orest_r; otr_nxt = otr_r; orem_nxt = orem_r; opr_nxt = opr_r;
    wr_en = 1'b0; wr_sel = best_r; wr_sh = bsh_r; wr_full = 1'b0;

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt  = in_tuser;
          id_nxt    = in_tdata[ID_BITS-1:0];
          side_nxt  = in_tdata[ID_BITS];
          rem_nxt   = in_tdata[ID_BITS+1 +: SHARE_BITS];
          lim_nxt   = in_tdata[ID_BITS+1+SHARE_BITS +: PRICE_BITS];
          idx_nxt   = '0;
          found_nxt = 1'b0;
          if (in_tuser == MODE_ADD && in_tdata[ID_BITS+1 +: SHARE_BITS] == '0) begin
            state_nxt = S_FINAL;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (better) begin
          found_nxt = 1'b1;
          best_nxt  = cur;
          bpr_nxt   = mem_pr[cur];
          bage_nxt  = age;
          bsh_nxt   = mem_sh[cur];
          bid_nxt   = mem_id[cur];
        end
        if (idx_r == SW'(ORDER_SLOTS - 1)) begin
          if (mode_r == MODE_CANCEL) begin
            state_nxt = S_FINAL;
          end else begin
            state_nxt = (found_r || better) ? S_FILL : S_FREE;
          end
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_FILL: begin
        if (!ov_r || out_tready) begin
          wr_en   = 1'b1;
          wr_sh   = bsh_r - traded;
          if (bsh_r == traded) begin
            valid_nxt[best_r] = 1'b0;
          end
          rem_nxt   = rem_r - traded;
          ov_nxt    = 1'b1;
          okind_nxt = KIND_FILL;
          olast_nxt = 1'b0;
          orest_nxt = bid_r;
          otr_nxt   = traded;
          opr_nxt   = bpr_r;
          orem_nxt  = rem_r - traded;
          found_nxt = 1'b0;
          idx_nxt   = '0;
          state_nxt = (rem_r == traded) ? S_FINAL : S_SCAN;
        end
      end
      S_FREE: begin
        if (!valid_r[cur] && !found_r) begin
          found_nxt = 1'b1;
          best_nxt  = cur;
        end
        if (idx_r == SW'(ORDER_SLOTS - 1)) begin
          state_nxt = S_FINAL;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_FINAL: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          olast_nxt = 1'b1;
          orest_nxt = '0;
          otr_nxt   = '0;
          opr_nxt   = '0;
          orem_nxt  = rem_r;
          if (mode_r == MODE_CANCEL) begin
            orem_nxt = '0;
            if (found_r) begin
              okind_nxt = KIND_CANCELLED;
              valid_nxt[best_r] = 1'b0;
            end else begin
              okind_nxt = KIND_NOT_FOUND;
            end
          end else if (rem_r == '0) begin
            okind_nxt = KIND_FILLED;
          end else if (found_r) begin
            okind_nxt = KIND_RESTED;
            valid_nxt[best_r] = 1'b1;
            wr_full     = 1'b1;
            arr_cnt_nxt = arr_cnt_r + 1'b1;
          end else begin
            okind_nxt = KIND_BOOK_FULL;
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_nxt) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_full) begin
      mem_id[best_r]   <= id_r;
      mem_side[best_r] <= side_r;
      mem_sh[best_r]   <= rem_r;
      mem_pr[best_r]   <= lim_r;
      mem_arr[best_r]  <= arr_cnt_r;
    end else if (wr_en) begin
      mem_sh[wr_sel] <= wr_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      arr_cnt_r <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      arr_cnt_r <= arr_cnt_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt; side_r <= side_nxt; id_r <= id_nxt;
    rem_r  <= rem_nxt;  lim_r  <= lim_nxt;
    idx_r <= idx_nxt; found_r <= found_nxt; best_r <= best_nxt;
    bpr_r <= bpr_nxt; bage_r <= bage_nxt; bsh_r <= bsh_nxt; bid_r <= bid_nxt;
    olast_r <= olast_nxt; okind_r <= okind_nxt; orest_r <= orest_nxt;
    otr_r <= otr_nxt; orem_r <= orem_nxt; opr_r <= opr_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = OUT_TW'({orem_r, opr_r, otr_r, orest_r, id_r});

endmodule
